// ===== design/omadg_pkg.sv =====
// Shared constants for the drift-gated offset moving average.
// Index and count widths follow from the window depth; no other file is needed.
package omadg_pkg;

    localparam int WINDOW  = 128;
    localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int SMP_W   = 32;
    localparam int DL_W    = 16;
    localparam int LVL_W   = 8;
    localparam int SUM_W   = SMP_W + IDX_W + 1;
    localparam int NUM_W   = SUM_W + 1;
    localparam int DEN_W   = CNT_W + 1;
    localparam int STEP_W  = $clog2(NUM_W + 1);
    localparam int LVL_MAX = (1 << LVL_W) - 1;

endpackage

// ===== design/omadg_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; no package needed.
module omadg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/omadg_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on omadg_pkg for operand widths.
module omadg_div
    import omadg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DEN_W:0]    trial;
    logic              fits;
    logic [DEN_W:0]    diff;

    // trial subtract of the divisor from the shifted remainder
    always_comb
    begin
        trial = {rem_reg, num_reg[NUM_W-1]};
        fits  = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    // control: count steps, flag completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // datapath: shift quotient bits into the numerator register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = num_reg;

endmodule

// ===== design/offset_moving_average_drift_gate.sv =====
// Top level of the drift-gated moving average of clock offset samples.
// Depends on omadg_pkg, omadg_ram and omadg_div.
//
// Usage:
//   s_* carries one 32-bit signed offset sample per beat. m_* returns one
//   result per sample: accepted flag in tuser, the rounded window mean and
//   the fill level in tdata. cfg_* writes the 16-bit drift limit; write it
//   only while no sample is in flight. cfg_ready is always high.
//   Before the first accepted sample any sample is taken; afterwards a
//   sample more than the drift limit away from the current mean is
//   rejected and leaves the window and the mean as they were.
// Flow:
//   A rejected sample goes from acceptance straight to the emit step. An
//   accepted sample goes through the window RAM read-modify-write and the
//   serial divider (one quotient bit per cycle, NUM_W bits, 41 here) before
//   the emit step. The emit step raises m_tvalid once the output register
//   is free, and only then is the next sample taken. One sample is in work
//   at a time.
// Reset and stall:
//   Reset clears the sum, fill count, write slot, sync flag and mean and
//   sets the drift limit to 1; the window RAM needs no clearing pass since
//   only written entries are read. A stalled receiver holds the result in
//   the output register; the next sample is taken meanwhile and waits to
//   be emitted until that register frees.
module offset_moving_average_drift_gate
    import omadg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // config write: drift_limit [15:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // s_tdata: sample_offset [31:0]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // m_tdata: average_offset [31:0], fill_level [39:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,
    // m_tuser: accepted [0]
    output logic [0:0]  m_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_PREP,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t                   state_reg;
    logic [DL_W-1:0]          drift_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]         fill_reg;
    logic [IDX_W-1:0]         wpos_reg;
    logic                     synced_reg;
    logic signed [SMP_W-1:0]  avg_reg;
    logic signed [SMP_W-1:0]  smp_reg;
    logic                     take_reg;
    logic                     full_reg;
    logic                     neg_reg;
    logic                     m_tvalid_reg;
    logic [39:0]              m_tdata_reg;
    logic [0:0]               m_tuser_reg;

    logic                     s_beat;
    logic                     full_now;
    logic                     take;
    logic signed [SMP_W+1:0]  smp_x;
    logic signed [SMP_W+1:0]  hi_bound;
    logic signed [SMP_W+1:0]  lo_bound;
    logic signed [SUM_W-1:0]  old_x;
    logic signed [SUM_W-1:0]  sum_upd;
    logic [SUM_W-1:0]         mag;
    logic [NUM_W-1:0]         numer;
    logic [DEN_W-1:0]         denom;
    logic                     div_start;
    logic                     div_busy;
    logic                     div_done;
    logic [NUM_W-1:0]         quot;
    logic [SMP_W-1:0]         mean_mag;
    logic [LVL_W-1:0]         lvl;
    logic                     out_free;
    logic                     ram_re;
    logic                     ram_we;
    logic [SMP_W-1:0]         ram_rdata;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_beat    = s_tvalid && s_tready;
    assign full_now  = (fill_reg == CNT_W'(WINDOW));
    assign out_free  = !m_tvalid_reg || m_tready;

    // drift gate against the current mean, bounds at full precision
    always_comb
    begin
        smp_x    = (SMP_W+2)'($signed(s_tdata));
        hi_bound = (SMP_W+2)'(avg_reg) + $signed({2'b00, 16'(drift_reg)});
        lo_bound = (SMP_W+2)'(avg_reg) - $signed({2'b00, 16'(drift_reg)});
        take     = !synced_reg || !((smp_x > hi_bound) || (smp_x < lo_bound));
    end

    // fetch the oldest entry when the window is full
    assign ram_re = s_beat && take && full_now;
    assign ram_we = (state_reg == ST_UPDATE);

    omadg_ram #(
        .WIDTH (SMP_W),
        .DEPTH (WINDOW)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wpos_reg),
        .wdata (smp_reg),
        .re    (ram_re),
        .raddr (wpos_reg),
        .rdata (ram_rdata)
    );

    // new window sum: drop the oldest entry if full, add the sample
    always_comb
    begin
        old_x   = full_reg ? SUM_W'($signed(ram_rdata)) : '0;
        sum_upd = sum_reg - old_x + SUM_W'(smp_reg);
    end

    // rounded mean operands: (2|sum| + n) / 2n
    always_comb
    begin
        mag       = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        numer     = {mag, 1'b0} + NUM_W'(fill_reg);
        denom     = {fill_reg, 1'b0};
        div_start = (state_reg == ST_PREP);
    end

    omadg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (numer),
        .denom (denom),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (quot)
    );

    assign mean_mag = quot[SMP_W-1:0];
    assign lvl = (32'(fill_reg) > 32'(LVL_MAX)) ? LVL_W'(LVL_MAX) : LVL_W'(fill_reg);

    // sequencer, window state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            drift_reg    <= DL_W'(1);
            sum_reg      <= '0;
            fill_reg     <= '0;
            wpos_reg     <= '0;
            synced_reg   <= 1'b0;
            avg_reg      <= '0;
            take_reg     <= 1'b0;
            full_reg     <= 1'b0;
            neg_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                drift_reg <= cfg_data;
            end

            // drop the output beat once taken, unless the emit step refills it
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT))
            begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_beat)
                    begin
                        smp_reg  <= s_tdata;
                        take_reg <= take;
                        full_reg <= full_now;
                        state_reg <= take ? ST_UPDATE : ST_EMIT;
                    end
                end
                ST_UPDATE:
                begin
                    sum_reg    <= sum_upd;
                    synced_reg <= 1'b1;
                    if (!full_reg)
                    begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    wpos_reg <= (wpos_reg == IDX_W'(WINDOW - 1)) ? '0 : wpos_reg + 1'b1;
                    state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    neg_reg   <= sum_reg[SUM_W-1];
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        avg_reg   <= neg_reg ? -$signed(mean_mag) : $signed(mean_mag);
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {lvl, avg_reg};
                        m_tuser_reg  <= take_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // a new output beat only comes from the emit step
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("output beat raised outside emit step");

    // no sample is taken while the divider works
    a_div_lock: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> !s_tready)
        else $error("input ready while divider busy");

    // an accepted result always reports a non-empty window
    a_acc_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_tuser_reg[0]) |-> (m_tdata_reg[39:32] != '0))
        else $error("accepted result with empty window");

    // fill count stays within the window
    a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPDATE) |=> (32'(fill_reg) <= 32'(WINDOW)))
        else $error("fill count beyond window depth");

endmodule
